>>> design/synth_voice_allocator_assert.svh
// Assertion macros shared by the voice allocator checker.
// Needs a clock and an active-low reset in scope at the point of use.
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SVALLOC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("voice allocator check failed");

// next-cycle implication
`define SVALLOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("voice allocator check failed");

`endif

>>> design/svalloc_pkg.sv
// Shared types, constants and helpers for the voice allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package svalloc_pkg;

  localparam int NumVoices   = 8;
  localparam int IdxW        = (NumVoices > 1) ? $clog2(NumVoices) : 1;
  localparam int OpW         = 2;
  localparam int NoteW       = 7;
  localparam int VoiceFieldW = 3;
  localparam int ActW        = 3;
  localparam int CfgW        = 4;
  localparam logic [CfgW-1:0] ActiveReset = CfgW'(8);

  typedef enum logic [OpW-1:0] {
    OpNoteOn   = 2'd0,
    OpNoteOff  = 2'd1,
    OpFinished = 2'd2
  } op_e;

  typedef enum logic [ActW-1:0] {
    ActRetrig   = 3'd0,
    ActSilent   = 3'd1,
    ActReleased = 3'd2,
    ActStolen   = 3'd3,
    ActRelease  = 3'd4,
    ActOffNone  = 3'd5,
    ActFinished = 3'd6
  } action_e;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [NoteW-1:0]       note;
    logic [VoiceFieldW-1:0] voice;
  } evt_t;

  typedef struct packed {
    logic [VoiceFieldW-1:0] voice_index;
    action_e                action;
    logic                   key_down;
    logic [NoteW-1:0]       last_note;
    logic                   last_note_valid;
  } res_t;

  // lowest set bit position, zero when none set
  function automatic logic [IdxW-1:0] first_set(input logic [NumVoices-1:0] v);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = NumVoices - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> design/svalloc_core.sv
// Voice bookkeeping state, active-count register and combinational allocation logic.
// Depends on svalloc_pkg.
`timescale 1ns / 1ps

module svalloc_core import svalloc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            fire_i,
  input  evt_t            evt_i,
  output res_t            res_o
);

  logic [NumVoices-1:0][NoteW-1:0] note_q, note_d;
  logic [NumVoices-1:0]            note_valid_q, note_valid_d;
  logic [NumVoices-1:0]            held_q, held_d;
  logic [NumVoices-1:0]            sounding_q, sounding_d;
  logic [NoteW-1:0]                recent_q, recent_d;
  logic                            recent_valid_q, recent_valid_d;
  logic                            key_q, key_d;
  logic [CfgW-1:0]                 active_q;

  logic [CfgW-1:0]      n_eff;
  logic [NumVoices-1:0] in_use, held_hit, silent, released;
  logic [IdxW-1:0]      vidx;
  logic [VoiceFieldW-1:0] res_vidx;
  action_e              act;

  always_comb begin
    if (active_q == '0) begin
      n_eff = CfgW'(1);
    end else if (int'(active_q) > NumVoices) begin
      n_eff = CfgW'(NumVoices);
    end else begin
      n_eff = active_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NumVoices; i++) begin
      in_use[i]   = i < int'(n_eff);
      held_hit[i] = in_use[i] && note_valid_q[i] && held_q[i] && (note_q[i] == evt_i.note);
      silent[i]   = in_use[i] && !sounding_q[i];
      released[i] = in_use[i] && sounding_q[i] && !held_q[i];
    end
  end

  always_comb begin
    note_d         = note_q;
    note_valid_d   = note_valid_q;
    held_d         = held_q;
    sounding_d     = sounding_q;
    recent_d       = recent_q;
    recent_valid_d = recent_valid_q;
    key_d          = key_q;
    vidx           = '0;
    act            = ActRetrig;
    res_vidx       = '0;
    unique case (evt_i.op)
      OpNoteOn: begin
        if (|held_hit) begin
          vidx = first_set(held_hit);
          act  = ActRetrig;
        end else if (|silent) begin
          vidx = first_set(silent);
          act  = ActSilent;
        end else if (|released) begin
          vidx = first_set(released);
          act  = ActReleased;
        end else begin
          vidx = '0;
          act  = ActStolen;
        end
        note_d[vidx]       = evt_i.note;
        note_valid_d[vidx] = 1'b1;
        held_d[vidx]       = 1'b1;
        sounding_d[vidx]   = 1'b1;
        key_d              = 1'b1;
        recent_d           = evt_i.note;
        recent_valid_d     = 1'b1;
        res_vidx           = VoiceFieldW'(vidx);
      end
      OpNoteOff: begin
        if (|held_hit) begin
          vidx         = first_set(held_hit);
          held_d[vidx] = 1'b0;
          act          = ActRelease;
          res_vidx     = VoiceFieldW'(vidx);
        end else begin
          act      = ActOffNone;
          res_vidx = '0;
        end
        if (recent_valid_q && (recent_q == evt_i.note)) begin
          key_d = 1'b0;
        end
      end
      OpFinished: begin
        act      = ActFinished;
        res_vidx = evt_i.voice;
        for (int i = 0; i < NumVoices; i++) begin
          if (int'(evt_i.voice) == i) begin
            sounding_d[i] = 1'b0;
            if (!held_q[i]) begin
              note_d[i]       = '0;
              note_valid_d[i] = 1'b0;
            end
          end
        end
      end
      default: begin
        act = ActRetrig;
      end
    endcase
  end

  assign res_o.voice_index     = res_vidx;
  assign res_o.action          = act;
  assign res_o.key_down        = key_d;
  assign res_o.last_note       = recent_d;
  assign res_o.last_note_valid = recent_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_q         <= '0;
      note_valid_q   <= '0;
      held_q         <= '0;
      sounding_q     <= '0;
      recent_q       <= '0;
      recent_valid_q <= 1'b0;
      key_q          <= 1'b0;
    end else if (fire_i) begin
      note_q         <= note_d;
      note_valid_q   <= note_valid_d;
      held_q         <= held_d;
      sounding_q     <= sounding_d;
      recent_q       <= recent_d;
      recent_valid_q <= recent_valid_d;
      key_q          <= key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveReset;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

endmodule

>>> design/svalloc_out_reg.sv
// Result register with valid/stall handshake toward the receiver.
// Depends on svalloc_pkg.
`timescale 1ns / 1ps

module svalloc_out_reg import svalloc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic stall_i,
  output logic ready_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> design/synth_voice_allocator.sv
// Polyphonic voice allocator: event input register, allocation core, result register.
// One item per cycle sustained while the receiver does not stall.
// Input: valid/stall with op, note, voice. Output: valid/stall with one result per
// note-on, note-off or finished item; op code 3 is consumed and yields no result.
// The item sits in the input register, where the allocation logic compares
// its note against all active voices in parallel and picks a voice; the voice
// state and the result register load together when the item fires, so each item
// sees the state left by the previous one.
// Throughput without stalls is one item per clock, set by one compare-and-pick stage.
// The active-voice register is written by cfg_we_i/cfg_wdata_i, reset value 8.
// Reset (rst_ni low, asynchronous) empties both registers, makes all voices
// silent with no note, clears key-down and last-note state.
// When the receiver stalls, the result holds; the item in the input register
// waits, and in_stall_o rises once the input register is full and cannot move.
// Depends on svalloc_pkg, svalloc_core, svalloc_out_reg.
`timescale 1ns / 1ps

module synth_voice_allocator import svalloc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OpW-1:0]         op_i,
  input  logic [NoteW-1:0]       note_i,
  input  logic [VoiceFieldW-1:0] voice_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [VoiceFieldW-1:0] voice_index_o,
  output logic [ActW-1:0]        action_o,
  output logic                   key_down_o,
  output logic [NoteW-1:0]       last_note_o,
  output logic                   last_note_valid_o
);

  logic s1_valid_q, s1_valid_d;
  evt_t s1_evt_q;
  logic accept, out_ready, op_unused, s1_drain, fire, load;
  res_t core_res, out_res;

  assign op_unused  = !((s1_evt_q.op == OpNoteOn) || (s1_evt_q.op == OpNoteOff) ||
                        (s1_evt_q.op == OpFinished));
  assign fire       = s1_valid_q && out_ready;
  assign load       = fire && !op_unused;
  assign s1_drain   = s1_valid_q && (out_ready || op_unused);
  assign in_stall_o = s1_valid_q && !s1_drain;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_drain) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_evt_q.op    <= op_i;
      s1_evt_q.note  <= note_i;
      s1_evt_q.voice <= voice_i;
    end
  end

  svalloc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .evt_i       (s1_evt_q),
    .res_o       (core_res)
  );

  svalloc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (core_res),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign voice_index_o     = out_res.voice_index;
  assign action_o          = out_res.action;
  assign key_down_o        = out_res.key_down;
  assign last_note_o       = out_res.last_note;
  assign last_note_valid_o = out_res.last_note_valid;

endmodule

>>> design/svalloc_checker.sv
// Port-level checks on the voice allocator results, bound to the top level.
// Depends on svalloc_pkg and synth_voice_allocator_assert.svh.
`timescale 1ns / 1ps
`include "synth_voice_allocator_assert.svh"

module svalloc_checker import svalloc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [VoiceFieldW-1:0] voice_index_o,
  input logic [ActW-1:0]        action_o,
  input logic                   key_down_o,
  input logic                   last_note_valid_o
);

  `SVALLOC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(voice_index_o) && $stable(action_o))
  `SVALLOC_ASSERT_NOW(a_unmatched_zero, clk_i, rst_ni, out_valid_o && (action_o == ActOffNone), voice_index_o == '0)
  `SVALLOC_ASSERT_NOW(a_stolen_zero, clk_i, rst_ni, out_valid_o && (action_o == ActStolen), voice_index_o == '0)
  `SVALLOC_ASSERT_NOW(a_note_on_flags, clk_i, rst_ni, out_valid_o && ((action_o == ActRetrig) || (action_o == ActSilent) || (action_o == ActReleased) || (action_o == ActStolen)), key_down_o && last_note_valid_o)

endmodule

bind synth_voice_allocator svalloc_checker u_svalloc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .voice_index_o     (voice_index_o),
  .action_o          (action_o),
  .key_down_o        (key_down_o),
  .last_note_valid_o (last_note_valid_o)
);

>>> verif/tb_synth_voice_allocator.sv
// Self-checking testbench for synth_voice_allocator: directed and randomized note events.
// Depends on svalloc_pkg and the DUT RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_synth_voice_allocator;
  import svalloc_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int PhaseItems = 113;

  class voice_alloc_scoreboard;
    logic [NoteW-1:0] voice_note [NumVoices];
    bit               note_assigned [NumVoices];
    bit               held [NumVoices];
    bit               sounding [NumVoices];
    logic [NoteW-1:0] recent;
    bit               recent_ok;
    bit               key_flag;
    logic [CfgW-1:0]  active_cfg;
    res_t             pending_results [$];
    int               mismatches;

    function new();
      for (int i = 0; i < NumVoices; i++) begin
        voice_note[i] = '0;
        note_assigned[i] = 1'b0;
        held[i] = 1'b0;
        sounding[i] = 1'b0;
      end
      recent = '0;
      recent_ok = 1'b0;
      key_flag = 1'b0;
      active_cfg = ActiveReset;
      mismatches = 0;
    endfunction

    function void set_active(logic [CfgW-1:0] v);
      active_cfg = v;
    endfunction

    function int used_voices();
      int n;
      n = int'(active_cfg);
      if (n < 1) n = 1;
      if (n > NumVoices) n = NumVoices;
      return n;
    endfunction

    function int held_voice(logic [NoteW-1:0] nt);
      for (int i = 0; i < used_voices(); i++) begin
        if (note_assigned[i] && voice_note[i] == nt && held[i]) return i;
      end
      return -1;
    endfunction

    // predict the result of one accepted event and queue it
    function void accept_event(evt_t e);
      res_t r;
      int   v;
      int   n;
      bit   found;
      r = '0;
      n = used_voices();
      case (e.op)
        OpNoteOn: begin
          v = held_voice(e.note);
          if (v >= 0) begin
            r.action = ActRetrig;
          end else begin
            found = 1'b0;
            for (int i = 0; i < n && !found; i++) begin
              if (!sounding[i]) begin
                v = i;
                r.action = ActSilent;
                found = 1'b1;
              end
            end
            for (int i = 0; i < n && !found; i++) begin
              if (sounding[i] && !held[i]) begin
                v = i;
                r.action = ActReleased;
                found = 1'b1;
              end
            end
            if (!found) begin
              v = 0;
              r.action = ActStolen;
            end
          end
          voice_note[v] = e.note;
          note_assigned[v] = 1'b1;
          held[v] = 1'b1;
          sounding[v] = 1'b1;
          key_flag = 1'b1;
          recent = e.note;
          recent_ok = 1'b1;
        end
        OpNoteOff: begin
          v = held_voice(e.note);
          if (v >= 0) begin
            held[v] = 1'b0;
            r.action = ActRelease;
          end else begin
            v = 0;
            r.action = ActOffNone;
          end
          if (recent_ok && recent == e.note) key_flag = 1'b0;
        end
        OpFinished: begin
          v = int'(e.voice);
          r.action = ActFinished;
          if (v < NumVoices) begin
            sounding[v] = 1'b0;
            if (!held[v]) begin
              voice_note[v] = '0;
              note_assigned[v] = 1'b0;
            end
          end
        end
        default: return;
      endcase
      r.voice_index = VoiceFieldW'(v);
      r.key_down = key_flag;
      r.last_note = recent;
      r.last_note_valid = recent_ok;
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: idx %0d act %0d kd %0d note %0d nv %0d",
                   got.voice_index, got.action, got.key_down, got.last_note,
                   got.last_note_valid);
        return;
      end
      want = pending_results.pop_front();
      if (got.voice_index !== want.voice_index || got.action !== want.action ||
          got.key_down !== want.key_down || got.last_note !== want.last_note ||
          got.last_note_valid !== want.last_note_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: want idx %0d act %0d kd %0d note %0d nv %0d, got idx %0d act %0d kd %0d note %0d nv %0d",
                   $realtime, want.voice_index, want.action, want.key_down,
                   want.last_note, want.last_note_valid, got.voice_index, got.action,
                   got.key_down, got.last_note, got.last_note_valid);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [OpW-1:0]         op_i = '0;
  logic [NoteW-1:0]       note_i = '0;
  logic [VoiceFieldW-1:0] voice_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [VoiceFieldW-1:0] voice_index_o;
  logic [ActW-1:0]        action_o;
  logic                   key_down_o;
  logic [NoteW-1:0]       last_note_o;
  logic                   last_note_valid_o;

  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  voice_alloc_scoreboard sb = new();

  synth_voice_allocator DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .note_i            (note_i),
    .voice_i           (voice_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .voice_index_o     (voice_index_o),
    .action_o          (action_o),
    .key_down_o        (key_down_o),
    .last_note_o       (last_note_o),
    .last_note_valid_o (last_note_valid_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_synth_voice_allocator failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.accept_event(evt_t'{op_i, note_i, voice_i});
      if (out_valid_o && !out_stall_i)
        sb.check_result(res_t'{voice_index_o, action_e'(action_o), key_down_o,
                               last_note_o, last_note_valid_o});
    end
  end

  task automatic send_item(logic [OpW-1:0] op, logic [NoteW-1:0] nt,
                           logic [VoiceFieldW-1:0] vc);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    note_i <= nt;
    voice_i <= vc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_active(logic [CfgW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_active(v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic directed_items();
    send_item(OpNoteOn, 7'd0, 3'd5);
    send_item(OpNoteOn, 7'd0, 3'd2);
    send_item(OpNoteOff, 7'd99, 3'd0);
    send_item(OpNoteOff, 7'd0, 3'd7);
    send_item(OpNoteOn, 7'd127, 3'd7);
    for (int n = 1; n <= 6; n++) send_item(OpNoteOn, NoteW'(n), 3'd0);
    send_item(OpNoteOn, 7'd50, 3'd1);
    send_item(OpNoteOn, 7'd51, 3'd6);
    send_item(OpFinished, 7'd127, 3'd3);
    send_item(OpFinished, 7'd0, 3'd7);
    send_item(OpNoteOn, 7'd52, 3'd4);
    send_item(OpNoteOff, 7'd52, 3'd3);
    send_item(OpFinished, 7'd52, 3'd3);
    send_item(OpNoteOff, 7'd127, 3'd1);
    send_item(OpNoteOn, 7'd60, 3'd0);
    send_item(OpNoteOff, 7'd1, 3'd0);
    send_item(OpUnused, 7'd127, 3'd7);
    send_item(OpFinished, 7'd60, 3'd0);
  endtask

  // mostly a small note pool so retrigger, release and steal paths get exercised
  task automatic random_items(int count);
    logic [NoteW-1:0]       pool [12];
    int                     pool_size;
    int                     sent;
    int                     pick;
    logic [OpW-1:0]         op;
    logic [NoteW-1:0]       nt;
    logic [VoiceFieldW-1:0] vc;
    pool_size = $urandom_range(2, 12);
    for (int i = 0; i < 12; i++) pool[i] = NoteW'($urandom_range(0, 127));
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OpNoteOn;
      else if (pick < 70) op = OpNoteOff;
      else if (pick < 95) op = OpFinished;
      else op = OpUnused;
      if ($urandom_range(0, 99) < 80) nt = pool[$urandom_range(0, pool_size - 1)];
      else nt = NoteW'($urandom_range(0, 127));
      if ($urandom_range(0, 99) < 75)
        vc = VoiceFieldW'($urandom_range(0, sb.used_voices() - 1));
      else
        vc = VoiceFieldW'($urandom_range(0, 7));
      send_item(op, nt, vc);
      if (op != OpUnused) sent++;
    end
  endtask

  initial begin
    logic [CfgW-1:0] plan [10];
    plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd12, 4'd5, 4'd2, 4'd7, 4'd4};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    settle();
    for (int p = 0; p < 10; p++) begin
      write_active(plan[p]);
      calm = (p == 3);
      random_items(PhaseItems);
      settle();
    end
    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_synth_voice_allocator passed");
    end else begin
      $display("tb_synth_voice_allocator failed");
    end
    $finish;
  end

endmodule

>>> synth_voice_allocator.f
+incdir+design
design/svalloc_pkg.sv
design/svalloc_core.sv
design/svalloc_out_reg.sv
design/synth_voice_allocator.sv
design/svalloc_checker.sv
verif/tb_synth_voice_allocator.sv
